@@ hdl/jsu_pkg.sv @@
// Package for the JSON string unescaper: shared types, status codes and
// character constants. No dependencies; every other file but jsu_in_if imports it.

package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_STR  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX  = 3'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_BYTE   = 3'd0,
        ST_CLOSED = 3'd1,
        ST_NOOPEN = 3'd2,
        ST_CTRL   = 3'd3,
        ST_BADESC = 3'd4,
        ST_BADHEX = 3'd5,
        ST_TRUNC  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CMD_BYTE   = 2'd0,
        CMD_STATUS = 2'd1,
        CMD_CODE   = 2'd2
    } cmd_op_t;

    // One queued request for the back end: a plain byte, a status, or a
    // code point that still has to be expanded to UTF-8.
    typedef struct packed {
        cmd_op_t     op;
        status_t     status;
        logic [15:0] data;
    } cmd_t;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_LOW_B   = 8'h62;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_LOW_N   = 8'h6e;
    localparam logic [7:0] CH_LOW_R   = 8'h72;
    localparam logic [7:0] CH_LOW_T   = 8'h74;
    localparam logic [7:0] CH_LOW_U   = 8'h75;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_FF      = 8'h0c;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [15:0] UTF8_MAX1 = 16'h007f;
    localparam logic [15:0] UTF8_MAX2 = 16'h07ff;
    localparam logic [7:0]  LEAD2     = 8'hc0;
    localparam logic [7:0]  LEAD3     = 8'he0;
    localparam logic [7:0]  CONT      = 8'h80;

endpackage

@@ hdl/jsu_in_if.sv @@
// Input channel of the JSON string unescaper: one text byte per request.
// Depends on nothing but the handshake convention valid/ready.

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       starts_string;
    logic       ends_input;

    modport source (output valid, data_byte, starts_string, ends_input, input ready);
    modport sink (input valid, data_byte, starts_string, ends_input, output ready);
endinterface

@@ hdl/jsu_out_if.sv @@
// Result channel of the JSON string unescaper: one decoded byte or status
// per request. Depends on jsu_pkg for the status type.

interface jsu_out_if import jsu_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    status_t    status;
    logic       last;

    modport source (output valid, out_byte, status, last, input ready);
    modport sink (input valid, out_byte, status, last, output ready);
endinterface

@@ hdl/jsu_front.sv @@
// Front end of the JSON string unescaper: accepts text bytes, tracks the
// string state and queues one request per input that has results.
// Depends on jsu_pkg and jsu_in_if.

module jsu_front import jsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    jsu_in_if.sink   text,
    input  logic     full,
    output logic     push,
    output cmd_t     push_cmd
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_accum_reg, code_accum_next;
    logic        accept;
    logic [4:0]  digit;
    logic [15:0] accum_shift;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    assign text.ready  = !full;
    assign accept      = text.valid && text.ready;
    assign digit       = hex_decode(text.data_byte);
    assign accum_shift = {code_accum_reg[11:0], digit[3:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            hex_count_reg  <= 2'd0;
            code_accum_reg <= 16'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hex_count_reg  <= hex_count_next;
            code_accum_reg <= code_accum_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        hex_count_next  = hex_count_reg;
        code_accum_next = code_accum_reg;
        push            = 1'b0;
        push_cmd        = '{op: CMD_STATUS, status: ST_BYTE, data: 16'd0};
        if (accept)
        begin
            if (text.starts_string)
            begin
                hex_count_next  = 2'd0;
                code_accum_next = 16'd0;
                if (text.ends_input || text.data_byte != CH_QUOTE)
                begin
                    phase_next      = PH_IDLE;
                    push            = 1'b1;
                    push_cmd.status = ST_NOOPEN;
                end
                else
                begin
                    phase_next = PH_STR;
                end
            end
            else if (text.ends_input)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    phase_next      = PH_IDLE;
                    hex_count_next  = 2'd0;
                    code_accum_next = 16'd0;
                    push            = 1'b1;
                    push_cmd.status = ST_TRUNC;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_STR:
                    begin
                        push = 1'b1;
                        if (text.data_byte == CH_QUOTE)
                        begin
                            phase_next      = PH_IDLE;
                            push_cmd.status = ST_CLOSED;
                        end
                        else if (text.data_byte < CTRL_LIMIT)
                        begin
                            phase_next      = PH_IDLE;
                            push_cmd.status = ST_CTRL;
                        end
                        else if (text.data_byte == CH_BSLASH)
                        begin
                            phase_next = PH_ESC;
                            push       = 1'b0;
                        end
                        else
                        begin
                            push_cmd.op   = CMD_BYTE;
                            push_cmd.data = {8'd0, text.data_byte};
                        end
                    end
                    PH_ESC:
                    begin
                        push        = 1'b1;
                        phase_next  = PH_STR;
                        push_cmd.op = CMD_BYTE;
                        unique case (text.data_byte) inside
                            CH_QUOTE, CH_BSLASH, CH_SLASH:
                                push_cmd.data = {8'd0, text.data_byte};
                            CH_LOW_B: push_cmd.data = {8'd0, CH_BS};
                            CH_LOW_F: push_cmd.data = {8'd0, CH_FF};
                            CH_LOW_N: push_cmd.data = {8'd0, CH_LF};
                            CH_LOW_R: push_cmd.data = {8'd0, CH_CR};
                            CH_LOW_T: push_cmd.data = {8'd0, CH_TAB};
                            CH_LOW_U:
                            begin
                                push            = 1'b0;
                                phase_next      = PH_HEX;
                                hex_count_next  = 2'd0;
                                code_accum_next = 16'd0;
                            end
                            default:
                            begin
                                phase_next      = PH_IDLE;
                                push_cmd.op     = CMD_STATUS;
                                push_cmd.status = ST_BADESC;
                            end
                        endcase
                    end
                    PH_HEX:
                    begin
                        if (!digit[4])
                        begin
                            phase_next      = PH_IDLE;
                            hex_count_next  = 2'd0;
                            code_accum_next = 16'd0;
                            push            = 1'b1;
                            push_cmd.status = ST_BADHEX;
                        end
                        else if (hex_count_reg != 2'd3)
                        begin
                            hex_count_next  = hex_count_reg + 2'd1;
                            code_accum_next = accum_shift;
                        end
                        else
                        begin
                            phase_next      = PH_STR;
                            hex_count_next  = 2'd0;
                            code_accum_next = 16'd0;
                            push            = 1'b1;
                            push_cmd.op     = CMD_CODE;
                            push_cmd.data   = accum_shift;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_error_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_cmd.op == CMD_STATUS |=> phase_reg == PH_IDLE)
        else $error("front did not return to idle after a status request");

    a_hex_count_only_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
        hex_count_reg != 2'd0 |-> phase_reg == PH_HEX)
        else $error("hex digit count left over outside a unicode escape");
`endif

endmodule

@@ hdl/jsu_queue.sv @@
// Short request queue between the front and back ends of the unescaper.
// Depends on jsu_pkg for the request type.

module jsu_queue import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("request popped from an empty queue");
`endif

endmodule

@@ hdl/jsu_back.sv @@
// Back end of the JSON string unescaper: expands queued requests into one
// result per cycle unless the output stalls, UTF-8 encoding code points,
// behind an output register. Depends on jsu_pkg and jsu_out_if.

module jsu_back import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  cmd_t      head_cmd,
    output logic      pop,
    jsu_out_if.source result
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] byte_reg, byte_next;
    status_t    status_reg, status_next;
    logic       last_reg, last_next;
    logic       load;
    logic       take;
    logic       is_last;
    logic [1:0] n_results;

    assign load = !valid_reg || result.ready;
    assign take = load && head_valid;

    always_comb
    begin
        n_results = 2'd1;
        if (head_cmd.op == CMD_CODE)
        begin
            if (head_cmd.data <= UTF8_MAX1) n_results = 2'd1;
            else if (head_cmd.data <= UTF8_MAX2) n_results = 2'd2;
            else n_results = 2'd3;
        end
    end

    assign is_last = idx_reg == n_results - 2'd1;
    assign pop     = take && is_last;

    always_comb
    begin
        byte_next   = 8'd0;
        status_next = ST_BYTE;
        unique case (head_cmd.op)
            CMD_BYTE: byte_next = head_cmd.data[7:0];
            CMD_STATUS: status_next = head_cmd.status;
            CMD_CODE:
            begin
                if (n_results == 2'd1)
                begin
                    byte_next = head_cmd.data[7:0];
                end
                else if (n_results == 2'd2)
                begin
                    byte_next = (idx_reg == 2'd0) ? (LEAD2 | {3'd0, head_cmd.data[10:6]})
                                                  : (CONT | {2'd0, head_cmd.data[5:0]});
                end
                else if (idx_reg == 2'd0)
                begin
                    byte_next = LEAD3 | {4'd0, head_cmd.data[15:12]};
                end
                else if (idx_reg == 2'd1)
                begin
                    byte_next = CONT | {2'd0, head_cmd.data[11:6]};
                end
                else
                begin
                    byte_next = CONT | {2'd0, head_cmd.data[5:0]};
                end
            end
            default: status_next = head_cmd.status;
        endcase
        last_next = is_last;
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = head_valid;
        end
        if (take)
        begin
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg   <= byte_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign result.valid    = valid_reg;
    assign result.out_byte = byte_reg;
    assign result.status   = status_reg;
    assign result.last     = last_reg;

`ifndef NO_ASSERTIONS
    a_status_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && status_reg != ST_BYTE |-> last_reg && byte_reg == 8'd0)
        else $error("status result carries data or is not the final result");
`endif

endmodule

@@ hdl/json_string_unescaper.sv @@
// JSON string unescaper: one text byte accepted per cycle unless the queue is
// full, decoded results delivered one per cycle while the result side is
// ready. Requests are registered in the queue, results in the output register;
// a unicode escape gives up to three results. Sustained rate is one input per
// cycle while the result side keeps up; a four-entry request queue absorbs bursts.
// Asynchronous active-low reset returns to idle and empties queue and output.

module json_string_unescaper import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    text,
    jsu_out_if.source result
);

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    jsu_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    jsu_queue #(.DEPTH(DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    jsu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .result     (result)
    );

endmodule
